>>> src/snes_pkg.sv
// Shared types, constants and fixed-point helpers for the neuron Euler step unit.
`default_nettype none
package snes_pkg;

  typedef logic signed [31:0] fix_t;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned StepW   = 21;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RECOVERY_RATE        = 4'd0,
    REG_RECOVERY_SENSITIVITY = 4'd1,
    REG_RESET_POTENTIAL      = 4'd2,
    REG_RECOVERY_JUMP        = 4'd3,
    REG_QUADRATIC_COEFF      = 4'd4,
    REG_LINEAR_COEFF         = 4'd5,
    REG_DRIVE_BIAS           = 4'd6,
    REG_STEP_SIZE            = 4'd7
  } reg_idx_e;

  localparam fix_t RstRecoveryRate   = 32'sd1311;
  localparam fix_t RstRecoverySens   = 32'sd13107;
  localparam fix_t RstResetPotential = -32'sd4259840;
  localparam fix_t RstRecoveryJump   = 32'sd131072;
  localparam fix_t RstQuadCoeff      = 32'sd2621;
  localparam fix_t RstLinearCoeff    = 32'sd327680;
  localparam fix_t RstDriveBias      = 32'sd9175040;
  localparam logic [StepW-1:0] RstStepSize = 21'd65536;

  localparam fix_t VReset      = -32'sd4587520;  // -70.0
  localparam fix_t UReset      = -32'sd917504;   // -14.0
  localparam fix_t Threshold   = 32'sd1966080;   // 30.0
  localparam fix_t SpikeLevel  = 32'sd1966080;   // 30.0

  localparam fix_t FixMax = 32'sh7fff_ffff;
  localparam fix_t FixMin = 32'sh8000_0000;

  // multiplier operand selects
  typedef enum logic [2:0] {
    MA_C1 = 3'd0,
    MA_T  = 3'd1,
    MA_H  = 3'd2,
    MA_B  = 3'd3,
    MA_A  = 3'd4
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_V  = 2'd0,
    MB_T  = 2'd1,
    MB_VN = 2'd2
  } mul_b_e;

  // second adder term next to the scaled product
  typedef enum logic [1:0] {
    ADD_NONE = 2'd0,
    ADD_C2   = 2'd1,
    ADD_V    = 2'd2,
    ADD_U    = 2'd3
  } add_e;

  typedef struct packed {
    logic   load_in;
    logic   mul_en;
    mul_a_e mul_a;
    mul_b_e mul_b;
    logic   alu_en;
    add_e   add_sel;
    logic   add_drive;  // add bias + both input currents
    logic   sub_u;
    logic   alu_to_vn;
    logic   commit;
  } snes_cmd_t;

  function automatic fix_t sat35(input logic signed [34:0] x);
    fix_t r;
    if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
      r = x[31:0];
    end else if (x[34]) begin
      r = FixMin;
    end else begin
      r = FixMax;
    end
    return r;
  endfunction

  function automatic fix_t sat48(input logic signed [47:0] x);
    fix_t r;
    if (x[47:31] == {17{1'b0}} || x[47:31] == {17{1'b1}}) begin
      r = x[31:0];
    end else if (x[47]) begin
      r = FixMin;
    end else begin
      r = FixMax;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/snes_if.sv
// Handshake channel interfaces: tick input, result output and register write.
`default_nettype none
interface snes_in_if;
  import snes_pkg::*;
  logic valid;
  logic ready;
  fix_t injected_current;
  fix_t synaptic_input;
  modport source (output valid, output injected_current, output synaptic_input, input ready);
  modport sink (input valid, input injected_current, input synaptic_input, output ready);
endinterface

interface snes_out_if;
  import snes_pkg::*;
  logic valid;
  logic ready;
  logic fired;
  fix_t potential_out;
  modport source (output valid, output fired, output potential_out, input ready);
  modport sink (input valid, input fired, input potential_out, output ready);
endinterface

interface snes_cfg_if;
  import snes_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/snes_ctrl.sv
// Sequencer for one Euler step: multiplier and adder schedule plus handshakes.
`default_nettype none
module snes_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output snes_pkg::snes_cmd_t      cmd_o
);
  import snes_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'h0001,
    S_M1   = 14'h0002,
    S_A1   = 14'h0004,
    S_M2   = 14'h0008,
    S_A2   = 14'h0010,
    S_M3   = 14'h0020,
    S_A3   = 14'h0040,
    S_M4   = 14'h0080,
    S_A4   = 14'h0100,
    S_M5   = 14'h0200,
    S_A5   = 14'h0400,
    S_M6   = 14'h0800,
    S_A6   = 14'h1000,
    S_FIN  = 14'h2000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_M1;
        end
      end
      S_M1: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_a = MA_C1; cmd_o.mul_b = MB_V;
        state_d      = S_A1;
      end
      S_A1: begin
        cmd_o.alu_en = 1'b1; cmd_o.add_sel = ADD_C2;
        state_d      = S_M2;
      end
      S_M2: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_a = MA_T; cmd_o.mul_b = MB_V;
        state_d      = S_A2;
      end
      S_A2: begin
        cmd_o.alu_en = 1'b1; cmd_o.add_drive = 1'b1; cmd_o.sub_u = 1'b1;
        state_d      = S_M3;
      end
      S_M3: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_a = MA_H; cmd_o.mul_b = MB_T;
        state_d      = S_A3;
      end
      S_A3: begin
        cmd_o.alu_en = 1'b1; cmd_o.add_sel = ADD_V; cmd_o.alu_to_vn = 1'b1;
        state_d      = S_M4;
      end
      S_M4: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_a = MA_B; cmd_o.mul_b = MB_VN;
        state_d      = S_A4;
      end
      S_A4: begin
        cmd_o.alu_en = 1'b1; cmd_o.sub_u = 1'b1;
        state_d      = S_M5;
      end
      S_M5: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_a = MA_A; cmd_o.mul_b = MB_T;
        state_d      = S_A5;
      end
      S_A5: begin
        cmd_o.alu_en = 1'b1;
        state_d      = S_M6;
      end
      S_M6: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_a = MA_H; cmd_o.mul_b = MB_T;
        state_d      = S_A6;
      end
      S_A6: begin
        cmd_o.alu_en = 1'b1; cmd_o.add_sel = ADD_U;
        state_d      = S_FIN;
      end
      S_FIN: begin
        // hold here until the output register can take the new beat
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

>>> src/snes_dp.sv
// Datapath: config registers, neuron state, shared multiplier and saturating adder.
`default_nettype none
module snes_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire snes_pkg::snes_cmd_t       cmd_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [snes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]               cfg_data_i,
  input  wire snes_pkg::fix_t            injected_current_i,
  input  wire snes_pkg::fix_t            synaptic_input_i,
  output logic                           fired_o,
  output snes_pkg::fix_t                 potential_out_o
);
  import snes_pkg::*;

  fix_t             rate_q, sens_q, vreset_q, jump_q, c1_q, c2_q, bias_q;
  logic [StepW-1:0] step_q;

  fix_t v_q, u_q;
  fix_t cur_q, syn_q;
  fix_t t_q, vn_q;
  logic signed [63:0] prod_q;

  fix_t               op_a, op_b, q32, addend, alu_res, u_jump;
  logic signed [34:0] sum;
  logic               fire;

  // config writes; indexes past the list fall to default and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RstRecoveryRate;
      sens_q   <= RstRecoverySens;
      vreset_q <= RstResetPotential;
      jump_q   <= RstRecoveryJump;
      c1_q     <= RstQuadCoeff;
      c2_q     <= RstLinearCoeff;
      bias_q   <= RstDriveBias;
      step_q   <= RstStepSize;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RECOVERY_RATE:        rate_q   <= cfg_data_i;
        REG_RECOVERY_SENSITIVITY: sens_q   <= cfg_data_i;
        REG_RESET_POTENTIAL:      vreset_q <= cfg_data_i;
        REG_RECOVERY_JUMP:        jump_q   <= cfg_data_i;
        REG_QUADRATIC_COEFF:      c1_q     <= cfg_data_i;
        REG_LINEAR_COEFF:         c2_q     <= cfg_data_i;
        REG_DRIVE_BIAS:           bias_q   <= cfg_data_i;
        REG_STEP_SIZE:            step_q   <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.mul_a)
      MA_C1:   op_a = c1_q;
      MA_T:    op_a = t_q;
      MA_H:    op_a = {{(32-StepW){1'b0}}, step_q};
      MA_B:    op_a = sens_q;
      MA_A:    op_a = rate_q;
      default: op_a = '0;
    endcase
    case (cmd_i.mul_b)
      MB_V:    op_b = v_q;
      MB_T:    op_b = t_q;
      MB_VN:   op_b = vn_q;
      default: op_b = '0;
    endcase
  end

  // arithmetic shift of the product is the floor of x*y/2^16
  assign q32 = sat48(prod_q[63:16]);

  always_comb begin
    case (cmd_i.add_sel)
      ADD_C2:  addend = c2_q;
      ADD_V:   addend = v_q;
      ADD_U:   addend = u_q;
      default: addend = '0;
    endcase
    sum = 35'(q32) + 35'(addend);
    if (cmd_i.add_drive) begin
      sum = sum + 35'(bias_q) + 35'(cur_q) + 35'(syn_q);
    end
    if (cmd_i.sub_u) begin
      sum = sum - 35'(u_q);
    end
    alu_res = sat35(sum);
  end

  assign fire   = (vn_q > Threshold);
  assign u_jump = sat35(35'(t_q) + 35'(jump_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q <= injected_current_i;
      syn_q <= synaptic_input_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.alu_en) begin
      if (cmd_i.alu_to_vn) begin
        vn_q <= alu_res;
      end else begin
        t_q <= alu_res;
      end
    end
    if (cmd_i.commit) begin
      fired_o         <= fire;
      potential_out_o <= fire ? SpikeLevel : vn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= VReset;
      u_q <= UReset;
    end else if (cmd_i.commit) begin
      v_q <= fire ? vreset_q : vn_q;
      u_q <= fire ? u_jump : t_q;
    end
  end

endmodule
`default_nettype wire

>>> src/spiking_neuron_euler_step_unit.sv
// Top level of the Izhikevich neuron Euler step unit.
// Each input beat is one simulation tick and yields exactly one result beat (spike flag and
// recorded potential). All values are signed Q16.16 with saturation. A tick occupies the
// block from acceptance until it returns to idle: six dependent products run through one
// shared 32x32 multiplier, each followed by a saturating add step, and a final step, which
// waits until the output register is free, commits the state and loads the output register.
// A finished result waits in the output register while the next tick is accepted. Register
// writes are taken in any cycle but must only be issued while the unit is idle.
`default_nettype none
module spiking_neuron_euler_step_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  snes_cfg_if.sink   cfg_i,
  snes_in_if.sink    in_i,
  snes_out_if.source out_o
);
  import snes_pkg::*;

  snes_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  snes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  snes_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_i.valid),
    .cfg_idx_i          (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .injected_current_i (in_i.injected_current),
    .synaptic_input_i   (in_i.synaptic_input),
    .fired_o            (out_o.fired),
    .potential_out_o    (out_o.potential_out)
  );

  // busy after taking a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while step in progress");

  // a spike always records the spike level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.fired |-> out_o.potential_out == SpikeLevel)
    else $error("spike beat with wrong potential");

  // a result beat never appears right after a tick is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && !out_o.valid |=> !out_o.valid)
    else $error("result produced without computation");

endmodule
`default_nettype wire
